FILE: rtl/rxd_pkg.sv
package rxd_pkg;

    // ring and frame constants
    localparam int unsigned RING_BYTES_DEF = 65536;
    localparam int unsigned HDR_BYTES      = 4;
    localparam logic [15:0] LEN_MIN        = 16'd18;
    localparam logic [15:0] LEN_MAX        = 16'd1518;
    localparam logic [15:0] REL_BACK       = 16'h0010;
    localparam logic [15:0] REL_MASK       = 16'hFFFC;
    localparam logic [10:0] COPY_LIMIT_RST = 11'd1514;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_DONE      = 2'd1,
        KIND_LEN_ERR   = 2'd2,
        KIND_NOT_READY = 2'd3
    } t_kind;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        logic [10:0] copied_len;
        logic [15:0] rx_status;
        logic [15:0] release_pointer;
    } t_result;

    // handshake between the input register and the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] ring_byte;
    } t_byte_slot;

endpackage

FILE: rtl/rxd_in_if.sv
interface rxd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ring_byte;

    modport source (output valid, output ring_byte, input ready);
    modport sink   (input valid, input ring_byte, output ready);
endinterface

FILE: rtl/rxd_out_if.sv
interface rxd_out_if;
    logic                valid;
    logic                ready;
    rxd_pkg::t_kind      kind;
    logic [7:0]          data;
    logic                last;
    logic [10:0]         copied_len;
    logic [15:0]         rx_status;
    logic [15:0]         release_pointer;

    modport source (output valid, output kind, output data, output last,
                    output copied_len, output rx_status, output release_pointer,
                    input ready);
    modport sink   (input valid, input kind, input data, input last,
                    input copied_len, input rx_status, input release_pointer,
                    output ready);
endinterface

FILE: rtl/rx_ring_frame_deframer.sv
// Receive ring deframer. Ring bytes arrive one per transfer on i_in, in ring
// order; each frame is a 4-byte little-endian header (status, length), the
// payload, a 4-byte crc and padding to a dword boundary. Payload bytes are
// forwarded up to copy_limit, the last one marked, and the final byte of the
// frame yields a frame done result with the copied count and the release
// pointer ((read offset - 0x10) & 0xFFFC, offset modulo RING_BYTES). A header
// with status bit 0 clear gives a not ready result and must be presented
// again; a length outside 18..1518 gives a length error and skips the header.
// One byte can be taken every clock cycle with no gaps. Each byte passes an
// input register and a result register, with the parser state update between
// the two registers; its result moves into the result register as the byte
// leaves the input register. A result held by a stalled receiver stops new
// bytes only when the next byte also has a result. copy_limit (reset 1514) is
// written through i_cfg_valid/o_cfg_ready and is sampled at each good header.
module rx_ring_frame_deframer #(
    parameter int unsigned RING_BYTES = rxd_pkg::RING_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rxd_in_if.sink      i_in,
    rxd_out_if.source   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_copy_limit
);

    rxd_pkg::t_byte_slot w_slot;
    rxd_pkg::t_result    w_result;
    logic                w_has_result;
    logic                w_out_free;
    logic                w_step;

    // a byte moves on when its result, if any, has a place to go
    assign w_step      = w_slot.valid && (!w_has_result || w_out_free);
    assign o_cfg_ready = 1'b1;

    rxd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_step),
        .o_slot  (w_slot)
    );

    rxd_parse #(
        .RING_BYTES (RING_BYTES)
    ) u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_copy_limit (i_cfg_copy_limit),
        .i_slot           (w_slot),
        .i_step           (w_step),
        .o_has_result     (w_has_result),
        .o_result         (w_result)
    );

    rxd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step && w_has_result),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_out    (o_out)
    );

endmodule

FILE: rtl/rxd_in_reg.sv
module rxd_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rxd_in_if.sink              i_in,
    input  logic                i_pop,
    output rxd_pkg::t_byte_slot o_slot
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_take;

    // room when empty or when the held byte moves on this cycle
    assign i_in.ready = !r_valid || i_pop;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // byte register, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_in.ring_byte;
        end
    end

    assign o_slot.valid     = r_valid;
    assign o_slot.ring_byte = r_byte;

endmodule

FILE: rtl/rxd_parse.sv
module rxd_parse #(
    parameter int unsigned RING_BYTES = rxd_pkg::RING_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_copy_limit,
    input  rxd_pkg::t_byte_slot i_slot,
    input  logic                i_step,
    output logic                o_has_result,
    output rxd_pkg::t_result    o_result
);

    localparam int unsigned OFF_W = $clog2(RING_BYTES);
    localparam logic [OFF_W:0] RING_SZ = (OFF_W+1)'(RING_BYTES);

    typedef enum logic {
        PH_HEADER,
        PH_BODY
    } t_phase;

    t_phase             r_phase,      n_phase;
    logic [1:0]         r_hidx,       n_hidx;
    logic [15:0]        r_status,     n_status;
    logic [7:0]         r_len_lo,     n_len_lo;
    logic [10:0]        r_frame_len,  n_frame_len;
    logic [10:0]        r_body_cnt,   n_body_cnt;
    logic [10:0]        r_copy_hold,  n_copy_hold;
    logic [OFF_W-1:0]   r_offset,     n_offset;
    logic [10:0]        r_copy_limit;

    logic [7:0]         w_byte;
    logic [15:0]        w_raw;
    logic [10:0]        w_pay;
    logic [10:0]        w_adv;
    logic [10:0]        w_total;
    logic [10:0]        w_cnt_inc;
    logic [10:0]        w_step_len;
    logic [OFF_W:0]     w_sum;
    logic [OFF_W-1:0]   w_off_next;
    logic [15:0]        w_release;

    assign w_byte    = i_slot.ring_byte;
    assign w_raw     = {w_byte, r_len_lo};
    assign w_pay     = w_raw[10:0] - 11'(rxd_pkg::HDR_BYTES);
    assign w_adv     = (r_frame_len + 11'd7) & ~11'd3;
    assign w_total   = w_adv - 11'(rxd_pkg::HDR_BYTES);
    assign w_cnt_inc = r_body_cnt + 11'd1;

    // one shared offset adder: header skip on a length error, frame span at the end
    assign w_step_len = (r_phase == PH_HEADER) ? 11'(rxd_pkg::HDR_BYTES) : w_adv;
    assign w_sum      = {1'b0, r_offset} + (OFF_W+1)'(w_step_len);
    assign w_off_next = (w_sum >= RING_SZ) ? OFF_W'(w_sum - RING_SZ) : w_sum[OFF_W-1:0];
    assign w_release  = (16'(w_off_next) - rxd_pkg::REL_BACK) & rxd_pkg::REL_MASK;

    // next state and result for the byte held at the input register
    always_comb begin
        n_phase      = r_phase;
        n_hidx       = r_hidx;
        n_status     = r_status;
        n_len_lo     = r_len_lo;
        n_frame_len  = r_frame_len;
        n_body_cnt   = r_body_cnt;
        n_copy_hold  = r_copy_hold;
        n_offset     = r_offset;
        o_has_result = 1'b0;
        o_result                 = '0;
        o_result.kind            = rxd_pkg::KIND_PAYLOAD;
        o_result.rx_status       = r_status;

        unique case (r_phase)
            PH_HEADER: begin
                unique case (r_hidx)
                    2'd0: begin
                        n_status = {8'h00, w_byte};
                        n_hidx   = 2'd1;
                    end
                    2'd1: begin
                        n_status = {w_byte, r_status[7:0]};
                        n_hidx   = 2'd2;
                    end
                    2'd2: begin
                        n_len_lo = w_byte;
                        n_hidx   = 2'd3;
                    end
                    default: begin
                        n_hidx = 2'd0;
                        if (!r_status[0]) begin
                            // source re-presents the header, offset kept
                            o_has_result  = 1'b1;
                            o_result.kind = rxd_pkg::KIND_NOT_READY;
                        end else if (w_raw < rxd_pkg::LEN_MIN || w_raw > rxd_pkg::LEN_MAX) begin
                            // skip the header only
                            n_offset                 = w_off_next;
                            o_has_result             = 1'b1;
                            o_result.kind            = rxd_pkg::KIND_LEN_ERR;
                            o_result.release_pointer = w_release;
                        end else begin
                            n_frame_len = w_raw[10:0];
                            n_copy_hold = (w_pay < r_copy_limit) ? w_pay : r_copy_limit;
                            n_body_cnt  = 11'd0;
                            n_phase     = PH_BODY;
                        end
                    end
                endcase
            end
            PH_BODY: begin
                n_body_cnt = w_cnt_inc;
                if (r_body_cnt < r_copy_hold) begin
                    o_has_result  = 1'b1;
                    o_result.kind = rxd_pkg::KIND_PAYLOAD;
                    o_result.data = w_byte;
                    o_result.last = (w_cnt_inc == r_copy_hold);
                end else if (w_cnt_inc >= w_total) begin
                    // final byte of crc and padding
                    n_offset                 = w_off_next;
                    n_phase                  = PH_HEADER;
                    n_hidx                   = 2'd0;
                    o_has_result             = 1'b1;
                    o_result.kind            = rxd_pkg::KIND_DONE;
                    o_result.copied_len      = r_copy_hold;
                    o_result.release_pointer = w_release;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        if (!i_slot.valid) begin
            o_has_result = 1'b0;
        end
    end

    // control state and copy limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hidx       <= 2'd0;
            r_offset     <= '0;
            r_copy_limit <= rxd_pkg::COPY_LIMIT_RST;
        end else begin
            if (i_step) begin
                r_phase  <= n_phase;
                r_hidx   <= n_hidx;
                r_offset <= n_offset;
            end
            if (i_cfg_we) begin
                r_copy_limit <= i_cfg_copy_limit;
            end
        end
    end

    // frame fields, always written before they are read
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_status    <= n_status;
            r_len_lo    <= n_len_lo;
            r_frame_len <= n_frame_len;
            r_body_cnt  <= n_body_cnt;
            r_copy_hold <= n_copy_hold;
        end
    end

endmodule

FILE: rtl/rxd_out_reg.sv
module rxd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rxd_pkg::t_result i_result,
    output logic             o_free,
    rxd_out_if.source        o_out
);

    logic             r_valid;
    rxd_pkg::t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // result register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.kind            = r_result.kind;
    assign o_out.data            = r_result.data;
    assign o_out.last            = r_result.last;
    assign o_out.copied_len      = r_result.copied_len;
    assign o_out.rx_status       = r_result.rx_status;
    assign o_out.release_pointer = r_result.release_pointer;

endmodule

FILE: rtl/rxd_checker.sv
module rxd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [7:0]  i_out_data,
    input logic        i_out_last,
    input logic [10:0] i_out_copied_len,
    input logic [15:0] i_out_release_pointer
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_data) && $stable(i_out_copied_len)
            && $stable(i_out_release_pointer))
        else $error("stalled result changed");

    // no result leaves right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // data and last only on payload bytes
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != 2'(rxd_pkg::KIND_PAYLOAD)
            |-> i_out_data == 8'h00 && !i_out_last)
        else $error("data or last on a non-payload result");

    // copied count only on frame done
    a_copied_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != 2'(rxd_pkg::KIND_DONE) |-> i_out_copied_len == 11'd0)
        else $error("copied count outside frame done");

    // release pointer is dword aligned
    a_rel_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_release_pointer[1:0] == 2'b00)
        else $error("release pointer not aligned");

endmodule

bind rx_ring_frame_deframer rxd_checker u_rxd_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_out_kind            (o_out.kind),
    .i_out_data            (o_out.data),
    .i_out_last            (o_out.last),
    .i_out_copied_len      (o_out.copied_len),
    .i_out_release_pointer (o_out.release_pointer)
);

FILE: dv/tb_rx_ring_frame_deframer.sv
module tb_rx_ring_frame_deframer;

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } t_phase;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TIMEOUT_UNITS = 4_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_copy_limit;

    rxd_in_if  ring_in ();
    rxd_out_if res_out ();

    rx_ring_frame_deframer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (ring_in),
        .o_out            (res_out),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_copy_limit (i_cfg_copy_limit)
    );

    // free running clock
    always #2 i_clk = ~i_clk;

    // deframer shadow state
    t_phase      pr_phase;
    logic [1:0]  pr_hdr_idx;
    logic [15:0] pr_status;
    logic [15:0] pr_len;
    logic [10:0] pr_body_cnt;
    logic [15:0] pr_rd_off;
    logic [10:0] pr_copy_hold;
    logic [10:0] pr_copy_limit;

    rxd_pkg::t_result expected_q[$];
    rxd_pkg::t_result head_res;

    int err_cnt     = 0;
    int n_bytes     = 0;
    int n_payload   = 0;
    int n_done      = 0;
    int n_len_err   = 0;
    int n_not_ready = 0;
    int n_limits    = 0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int snd_quiet    = 0;
    int rcv_quiet    = 0;

    function logic [15:0] release_ptr(input logic [15:0] off);
        logic [15:0] back;
        back = off - rxd_pkg::REL_BACK;
        return back & rxd_pkg::REL_MASK;
    endfunction

    function logic [15:0] ring_advance(input logic [15:0] off, input int unsigned n);
        int unsigned s;
        s = (off + n) % rxd_pkg::RING_BYTES_DEF;
        return s[15:0];
    endfunction

    function rxd_pkg::t_result make_result(input rxd_pkg::t_kind k, input logic [7:0] d,
                                           input logic l, input logic [10:0] c,
                                           input logic [15:0] rel);
        rxd_pkg::t_result r;
        r.kind            = k;
        r.data            = d;
        r.last            = l;
        r.copied_len      = c;
        r.rx_status       = pr_status;
        r.release_pointer = rel;
        return r;
    endfunction

    // advance the shadow deframer by one ring byte and queue what it yields
    task predict_ring_byte(input logic [7:0] b);
        logic [15:0] raw;
        logic [15:0] pay;
        logic [15:0] adv;
        logic [10:0] idx;
        if (pr_phase == PH_HEADER) begin
            case (pr_hdr_idx)
                2'd0: begin
                    pr_status  = {8'h00, b};
                    pr_hdr_idx = 2'd1;
                end
                2'd1: begin
                    pr_status[15:8] = b;
                    pr_hdr_idx      = 2'd2;
                end
                2'd2: begin
                    pr_len     = {8'h00, b};
                    pr_hdr_idx = 2'd3;
                end
                default: begin
                    pr_hdr_idx = 2'd0;
                    raw = {b, pr_len[7:0]};
                    if (!pr_status[0]) begin
                        // header not ready, offset stays put
                        expected_q.push_back(make_result(rxd_pkg::KIND_NOT_READY, 8'h00,
                                                         1'b0, 11'd0, 16'h0000));
                    end else if (raw < rxd_pkg::LEN_MIN || raw > rxd_pkg::LEN_MAX) begin
                        // bad length skips the header only
                        pr_rd_off = ring_advance(pr_rd_off, rxd_pkg::HDR_BYTES);
                        expected_q.push_back(make_result(rxd_pkg::KIND_LEN_ERR, 8'h00,
                                                         1'b0, 11'd0,
                                                         release_ptr(pr_rd_off)));
                    end else begin
                        pr_len       = raw;
                        pay          = raw - 16'd4;
                        pr_copy_hold = (pay < pr_copy_limit) ? pay[10:0] : pr_copy_limit;
                        pr_body_cnt  = 11'd0;
                        pr_phase     = PH_BODY;
                    end
                end
            endcase
        end else begin
            idx         = pr_body_cnt;
            adv         = (pr_len + 16'd7) & ~16'd3;
            pr_body_cnt = pr_body_cnt + 11'd1;
            if (idx < pr_copy_hold) begin
                expected_q.push_back(make_result(rxd_pkg::KIND_PAYLOAD, b,
                                                 (idx + 11'd1 == pr_copy_hold),
                                                 11'd0, 16'h0000));
            end else if (pr_body_cnt >= adv - 16'd4) begin
                // final byte of crc and padding closes the frame
                pr_rd_off  = ring_advance(pr_rd_off, adv);
                pr_phase   = PH_HEADER;
                pr_hdr_idx = 2'd0;
                expected_q.push_back(make_result(rxd_pkg::KIND_DONE, 8'h00, 1'b0,
                                                 pr_copy_hold, release_ptr(pr_rd_off)));
            end
        end
    endtask

    task check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_out.valid && res_out.ready) begin
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: kind %0d", res_out.kind);
                err_cnt++;
            end else begin
                head_res = expected_q.pop_front();
                check_field("kind", head_res.kind, res_out.kind);
                check_field("data", head_res.data, res_out.data);
                check_field("last", head_res.last, res_out.last);
                check_field("copied_len", head_res.copied_len, res_out.copied_len);
                check_field("rx_status", head_res.rx_status, res_out.rx_status);
                check_field("release_pointer", head_res.release_pointer,
                            res_out.release_pointer);
                case (head_res.kind)
                    rxd_pkg::KIND_PAYLOAD: n_payload++;
                    rxd_pkg::KIND_DONE:    n_done++;
                    rxd_pkg::KIND_LEN_ERR: n_len_err++;
                    default:               n_not_ready++;
                endcase
            end
        end
    end

    // receiver backpressure with occasional stall-free stretches
    always @(posedge i_clk) begin
        if (rcv_quiet > 0) begin
            rcv_quiet     <= rcv_quiet - 1;
            res_out.ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0)
                rcv_quiet <= $urandom_range(20, 80);
            res_out.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // one ring byte transfer, with random gaps in front of it
    task send_byte(input logic [7:0] b);
        if (snd_quiet > 0)
            snd_quiet--;
        else if ($urandom_range(0, 199) == 0)
            snd_quiet = $urandom_range(20, 80);
        while (snd_quiet == 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            ring_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        ring_in.valid     <= 1'b1;
        ring_in.ring_byte <= b;
        do @(posedge i_clk); while (!ring_in.ready);
        predict_ring_byte(b);
        n_bytes++;
    endtask

    // header plus, for a good header, the whole body with crc and padding
    task send_frame(input logic [15:0] status, input logic [15:0] len);
        int unsigned body;
        send_byte(status[7:0]);
        send_byte(status[15:8]);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (status[0] && len >= rxd_pkg::LEN_MIN && len <= rxd_pkg::LEN_MAX) begin
            body = ((len + 7) & ~3) - 4;
            repeat (body) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // stop sending until every queued result is out and the pipe is empty
    task wait_results;
        ring_in.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_copy_limit(input logic [10:0] value);
        wait_results();
        i_cfg_valid      <= 1'b1;
        i_cfg_copy_limit <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        pr_copy_limit = value;
        n_limits++;
        i_cfg_valid <= 1'b0;
    endtask

    task test_reset_limit;
        send_frame(16'h0001, rxd_pkg::LEN_MIN);
        send_frame(16'hFFFF, 16'd64);
    endtask

    // status bit 0 clear twice, then the header comes again once ready
    task test_not_ready;
        send_frame(16'h0000, 16'd64);
        send_frame(16'hFFFE, rxd_pkg::LEN_MIN);
        send_frame(16'h0001, 16'd64);
    endtask

    task test_length_errors;
        send_frame(16'hFFFF, rxd_pkg::LEN_MIN - 16'd1);
        send_frame(16'h0001, rxd_pkg::LEN_MAX + 16'd1);
        send_frame(16'h8001, 16'h0000);
        send_frame(16'hFFFF, 16'hFFFF);
        send_frame(16'h00FF, rxd_pkg::LEN_MIN);
    endtask

    task test_copy_limits;
        write_copy_limit(11'd0);
        send_frame(16'h0001, rxd_pkg::LEN_MIN);
        send_frame(16'h5A5B, 16'd40);
        write_copy_limit(11'd1);
        send_frame(16'h0001, rxd_pkg::LEN_MIN);
        write_copy_limit(11'd14);
        send_frame(16'h0003, rxd_pkg::LEN_MIN);
        write_copy_limit(11'd2047);
        send_frame(16'h7FFF, 16'd100);
        write_copy_limit(rxd_pkg::COPY_LIMIT_RST);
    endtask

    task random_frames(input int n_target);
        int          stop_at;
        int          pick;
        logic [15:0] st;
        logic [15:0] len;
        stop_at = n_bytes + n_target;
        while (n_bytes < stop_at) begin
            // realign on a header if junk happened to open a frame
            while (!(pr_phase == PH_HEADER && pr_hdr_idx == 2'd0))
                send_byte(8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 99);
            st   = 16'($urandom);
            len  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(41, 200))
                                               : 16'($urandom_range(18, 40));
            if (pick < 6) begin
                repeat (4) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 12) begin
                send_frame(st & 16'hFFFE, len);
                send_frame(st | 16'h0001, len);
            end else if (pick < 18) begin
                if ($urandom_range(0, 1) == 0)
                    len = 16'($urandom_range(0, 17));
                else
                    len = 16'($urandom_range(1519, 65535));
                send_frame(st | 16'h0001, len);
            end else if (pick < 22) begin
                if ($urandom_range(0, 1) == 0)
                    write_copy_limit(11'($urandom_range(0, 2047)));
                else
                    write_copy_limit(11'($urandom_range(0, 40)));
            end else begin
                send_frame(st | 16'h0001, len);
            end
        end
    endtask

    initial begin
        ring_in.valid     <= 1'b0;
        ring_in.ring_byte <= 8'h00;
        i_cfg_valid       <= 1'b0;
        i_cfg_copy_limit  <= 11'd0;
        i_rst_n           <= 1'b0;
        pr_phase      = PH_HEADER;
        pr_hdr_idx    = 2'd0;
        pr_status     = 16'h0000;
        pr_len        = 16'h0000;
        pr_body_cnt   = 11'd0;
        pr_rd_off     = 16'h0000;
        pr_copy_hold  = 11'd0;
        pr_copy_limit = rxd_pkg::COPY_LIMIT_RST;
        set_idling(27, 56);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_limit();
        test_not_ready();
        test_length_errors();
        test_copy_limits();
        random_frames(300);

        wait_results();
        set_idling(56, 27);
        random_frames(300);

        wait_results();
        set_idling(0, 0);
        random_frames(280);

        wait_results();
        $display("covered %0d ring bytes, %0d copy limit writes and three idling mixes",
                 n_bytes, n_limits);
        $display("results seen: %0d payload, %0d done, %0d length error, %0d not ready",
                 n_payload, n_done, n_len_err, n_not_ready);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_UNITS);
        $display("tb: failure");
        $finish;
    end

endmodule
